@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros shared by mlfq_front and mlfq_back
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/mlfq_pkg.sv @@
// ----------------------------------------------------------------------------
// mlfq_pkg
// Types, codes and fixed widths of the three-level feedback queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfq_pkg;

    // fixed field widths
    localparam int unsigned QUANTUM_W  = 16;
    localparam int unsigned PERIOD_W   = 4;
    localparam int unsigned BURST_W    = 16;
    localparam int unsigned PID_W      = 4;
    localparam int unsigned BEFORE_W   = 16;
    localparam int unsigned CLOCK_W    = 20;
    localparam int unsigned SUM_W      = 24;
    localparam int unsigned TOTAL_W    = 5;
    localparam int unsigned LEVEL_W    = 2;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned OUTCOME_W  = 2;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CLOCK_W-1:0] CLOCK_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

    // stream packing
    localparam int unsigned S_FIELDS_W = LEVEL_W + BURST_W;
    localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_FIELDS_W = PID_W + LEVEL_W + BEFORE_W + OUTCOME_W + CLOCK_W
                                       + SUM_W + SUM_W + TOTAL_W;
    localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_QUANTUM  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_QUANTUM = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROMOTE_PERIOD = 2'd2;

    localparam logic [QUANTUM_W-1:0] FIRST_QUANTUM_RST  = 16'd8;
    localparam logic [QUANTUM_W-1:0] SECOND_QUANTUM_RST = 16'd16;
    localparam logic [PERIOD_W-1:0]  PROMOTE_PERIOD_RST = 4'd4;

    // queue levels
    typedef logic [LEVEL_W-1:0] level_t;
    localparam level_t LEVEL_ZERO = 2'd0;
    localparam level_t LEVEL_ONE  = 2'd1;
    localparam level_t LEVEL_TWO  = 2'd2;

    // depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic {
        KIND_ADMIT = 1'b0,
        KIND_STEP  = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ADMITTED   = 2'd0,
        STATUS_REJECTED   = 2'd1,
        STATUS_DISPATCHED = 2'd2,
        STATUS_EMPTY      = 2'd3
    } status_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_FINISHED = 2'd0,
        OUTCOME_TO_ONE   = 2'd1,
        OUTCOME_PROMOTED = 2'd2,
        OUTCOME_TO_TWO   = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_SUM  = 2'd2,
        S_POST = 2'd3
    } state_t;

    typedef struct packed {
        kind_t               kind;
        level_t              level;
        logic [BURST_W-1:0]  burst;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic [PID_W-1:0]     process_id;
        level_t               served_level;
        logic [BEFORE_W-1:0]  time_before_run;
        outcome_t             outcome;
        logic [CLOCK_W-1:0]   now_time;
        logic [SUM_W-1:0]     completion_total;
        logic [SUM_W-1:0]     waiting_total;
        logic [TOTAL_W-1:0]   process_total;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/mlfq_front.sv @@
// ----------------------------------------------------------------------------
// mlfq_front
// Takes input items, decodes kind and level, and holds them in a short queue
// until the back end is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mlfq_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [mlfq_pkg::S_TDATA_W-1:0]      s_tdata,   // queue_level, burst_time
    input  wire logic                                s_tuser,   // action
    output logic                                     item_valid,
    output mlfq_pkg::item_t                          item,
    input  wire logic                                item_ready
);

    localparam int unsigned PTR_W = $clog2(mlfq_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(mlfq_pkg::QUEUE_DEPTH + 1);

    mlfq_pkg::item_t    slot_reg [mlfq_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    mlfq_pkg::item_t    decoded;
    mlfq_pkg::level_t   level_in;
    logic               push, pop;

    // level three folds into level two
    always_comb begin
        level_in      = s_tdata[mlfq_pkg::LEVEL_W-1:0];
        decoded.kind  = mlfq_pkg::kind_t'(s_tuser);
        decoded.level = (level_in > mlfq_pkg::LEVEL_TWO) ? mlfq_pkg::LEVEL_TWO : level_in;
        decoded.burst = s_tdata[mlfq_pkg::LEVEL_W +: mlfq_pkg::BURST_W];
    end

    assign s_tready   = (count_reg != CNT_W'(mlfq_pkg::QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = slot_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(mlfq_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(mlfq_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

    `ASSERT_ALWAYS(a_fill_in_range, aclk, aresetn, count_reg <= CNT_W'(mlfq_pkg::QUEUE_DEPTH))
    `ASSERT_NEXT(a_fill_grows_on_push, aclk, aresetn, push && !pop,
                 count_reg == $past(count_reg) + 1'b1)
    `ASSERT_NEXT(a_fill_drops_on_pop, aclk, aresetn, pop && !push,
                 count_reg == $past(count_reg) - 1'b1)

endmodule

`default_nettype wire

@@ hw/rtl/mlfq_back.sv @@
// ----------------------------------------------------------------------------
// mlfq_back
// Carries out admits and scheduling steps: three circular queues in one
// memory, the clock, the saturating sums and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mlfq_back #(
    parameter int unsigned MAX_PROCESSES = 16,
    parameter int unsigned TIME_WIDTH    = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    input  wire logic [mlfq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [mlfq_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 item_valid,
    input  wire mlfq_pkg::item_t                      item,
    output logic                                      item_ready,
    output logic                                      m_valid,
    output mlfq_pkg::result_t                         m_result,
    input  wire logic                                 m_ready
);

    localparam int unsigned IDX_W   = $clog2(MAX_PROCESSES);
    localparam int unsigned CNT_W   = $clog2(MAX_PROCESSES + 1);
    localparam int unsigned DEPTH   = 3 * MAX_PROCESSES;
    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned ENTRY_W = IDX_W + 2 * TIME_WIDTH;
    localparam int unsigned RUN_W   = (TIME_WIDTH > mlfq_pkg::QUANTUM_W) ? TIME_WIDTH
                                    : mlfq_pkg::QUANTUM_W;
    localparam int unsigned ADV_W   = ((RUN_W > mlfq_pkg::CLOCK_W) ? RUN_W
                                    : mlfq_pkg::CLOCK_W) + 1;
    localparam int unsigned DIFF_W  = (TIME_WIDTH > mlfq_pkg::CLOCK_W) ? TIME_WIDTH
                                    : mlfq_pkg::CLOCK_W;
    localparam int unsigned SUMC_W  = mlfq_pkg::SUM_W + 1;
    localparam int unsigned QSUM_W  = CNT_W + 2;

    function automatic logic [ADDR_W-1:0] slot_addr(input mlfq_pkg::level_t lvl,
                                                   input logic [IDX_W-1:0] idx);
        slot_addr = ADDR_W'(lvl) * ADDR_W'(MAX_PROCESSES) + ADDR_W'(idx);
    endfunction

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        idx_inc = (idx == IDX_W'(MAX_PROCESSES - 1)) ? '0 : idx + 1'b1;
    endfunction

    // state and configuration
    mlfq_pkg::state_t                   state_reg, state_next;
    logic [mlfq_pkg::QUANTUM_W-1:0]     fq_reg, sq_reg;
    logic [mlfq_pkg::PERIOD_W-1:0]      pp_reg;
    logic [IDX_W-1:0]                   head_reg  [3];
    logic [IDX_W-1:0]                   tail_reg  [3];
    logic [CNT_W-1:0]                   count_reg [3];
    logic [mlfq_pkg::CLOCK_W-1:0]       clock_reg;
    logic [mlfq_pkg::SUM_W-1:0]         comp_reg, wsum_reg;
    logic [mlfq_pkg::PERIOD_W-1:0]      prom_reg;
    logic [CNT_W-1:0]                   admit_reg;
    logic                               out_valid_reg;

    // per-step payload
    mlfq_pkg::level_t                   lvl_reg;
    logic [IDX_W-1:0]                   pid_reg;
    logic [mlfq_pkg::BEFORE_W-1:0]      before_reg;
    logic [TIME_WIDTH-1:0]              burst_reg;
    mlfq_pkg::outcome_t                 outcome_reg;
    logic                               fin_reg;
    logic [mlfq_pkg::CLOCK_W-1:0]       winc_reg;
    mlfq_pkg::result_t                  out_reg;

    logic [ENTRY_W-1:0]                 mem [DEPTH];
    logic [ENTRY_W-1:0]                 rd_data_reg;

    // combinational
    logic                               out_free, is_admit, full, queue_empty, pop, load_out;
    mlfq_pkg::level_t                   sel_lvl, target_lvl;
    logic                               mem_we;
    logic [ADDR_W-1:0]                  wr_addr, rd_addr;
    logic [ENTRY_W-1:0]                 wr_data;
    logic [IDX_W-1:0]                   e_id;
    logic [TIME_WIDTH-1:0]              e_rem, e_burst, new_rem;
    logic [RUN_W-1:0]                   rem_x, q_x, amount;
    logic                               gt;
    logic [ADV_W-1:0]                   clock_sum;
    logic [mlfq_pkg::CLOCK_W-1:0]       clock_adv;
    mlfq_pkg::outcome_t                 exec_outcome;
    logic [mlfq_pkg::PERIOD_W-1:0]      period, prom_next;
    logic [mlfq_pkg::PERIOD_W:0]        prom_inc;
    logic [SUMC_W-1:0]                  comp_sum, wsum_sum;
    logic [mlfq_pkg::SUM_W-1:0]         comp_sat, wsum_sat;
    logic [DIFF_W-1:0]                  clk_x, burst_x;
    logic [mlfq_pkg::CLOCK_W-1:0]       wait_inc;
    mlfq_pkg::result_t                  result_next;
    logic [QSUM_W-1:0]                  queued_total;

    assign out_free     = !out_valid_reg || m_ready;
    assign is_admit     = (item.kind == mlfq_pkg::KIND_ADMIT);
    assign full         = (admit_reg == CNT_W'(MAX_PROCESSES));
    assign queue_empty  = (count_reg[0] == '0) && (count_reg[1] == '0) && (count_reg[2] == '0);
    assign queued_total = QSUM_W'(count_reg[0]) + QSUM_W'(count_reg[1])
                        + QSUM_W'(count_reg[2]);

    always_comb begin
        priority if (count_reg[0] != '0) begin
            sel_lvl = mlfq_pkg::LEVEL_ZERO;
        end else if (count_reg[1] != '0) begin
            sel_lvl = mlfq_pkg::LEVEL_ONE;
        end else begin
            sel_lvl = mlfq_pkg::LEVEL_TWO;
        end
    end

    // run of the fetched entry
    always_comb begin
        e_id     = rd_data_reg[ENTRY_W-1 -: IDX_W];
        e_rem    = rd_data_reg[TIME_WIDTH +: TIME_WIDTH];
        e_burst  = rd_data_reg[TIME_WIDTH-1:0];
        rem_x    = RUN_W'(e_rem);
        q_x      = (lvl_reg == mlfq_pkg::LEVEL_ZERO) ? RUN_W'(fq_reg) : RUN_W'(sq_reg);
        gt       = (lvl_reg != mlfq_pkg::LEVEL_TWO) && (rem_x > q_x);
        amount   = gt ? q_x : rem_x;
        new_rem  = TIME_WIDTH'(rem_x - q_x);
        clock_sum = ADV_W'(clock_reg) + ADV_W'(amount);
        clock_adv = (clock_sum > ADV_W'(mlfq_pkg::CLOCK_MAX)) ? mlfq_pkg::CLOCK_MAX
                  : mlfq_pkg::CLOCK_W'(clock_sum);

        period   = (pp_reg == '0) ? mlfq_pkg::PERIOD_W'(1) : pp_reg;
        prom_inc = {1'b0, prom_reg} + 1'b1;
        prom_next = (prom_inc >= {1'b0, period}) ? '0 : prom_inc[mlfq_pkg::PERIOD_W-1:0];

        priority if (!gt) begin
            target_lvl   = mlfq_pkg::LEVEL_TWO;
            exec_outcome = mlfq_pkg::OUTCOME_FINISHED;
        end else if (lvl_reg == mlfq_pkg::LEVEL_ZERO) begin
            target_lvl   = mlfq_pkg::LEVEL_ONE;
            exec_outcome = mlfq_pkg::OUTCOME_TO_ONE;
        end else if (prom_reg == '0) begin
            target_lvl   = mlfq_pkg::LEVEL_ZERO;
            exec_outcome = mlfq_pkg::OUTCOME_PROMOTED;
        end else begin
            target_lvl   = mlfq_pkg::LEVEL_TWO;
            exec_outcome = mlfq_pkg::OUTCOME_TO_TWO;
        end
    end

    // totals of a finished process
    always_comb begin
        comp_sum = SUMC_W'(comp_reg) + SUMC_W'(clock_reg);
        comp_sat = comp_sum[mlfq_pkg::SUM_W] ? mlfq_pkg::SUM_MAX
                 : comp_sum[mlfq_pkg::SUM_W-1:0];
        clk_x    = DIFF_W'(clock_reg);
        burst_x  = DIFF_W'(burst_reg);
        wait_inc = (clk_x > burst_x) ? mlfq_pkg::CLOCK_W'(clk_x - burst_x) : '0;
        wsum_sum = SUMC_W'(wsum_reg) + SUMC_W'(winc_reg);
        wsum_sat = wsum_sum[mlfq_pkg::SUM_W] ? mlfq_pkg::SUM_MAX
                 : wsum_sum[mlfq_pkg::SUM_W-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mlfq_pkg::S_IDLE: begin
                if (item_valid && !is_admit && !queue_empty) begin
                    state_next = mlfq_pkg::S_EXEC;
                end
            end
            mlfq_pkg::S_EXEC: state_next = mlfq_pkg::S_SUM;
            mlfq_pkg::S_SUM:  state_next = mlfq_pkg::S_POST;
            mlfq_pkg::S_POST: begin
                if (out_free) begin
                    state_next = mlfq_pkg::S_IDLE;
                end
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        item_ready = 1'b0;
        mem_we     = 1'b0;
        wr_addr    = slot_addr(item.level, tail_reg[item.level]);
        wr_data    = {IDX_W'(admit_reg), TIME_WIDTH'(item.burst), TIME_WIDTH'(item.burst)};
        rd_addr    = slot_addr(sel_lvl, head_reg[sel_lvl]);
        load_out   = 1'b0;

        result_next.status           = mlfq_pkg::STATUS_EMPTY;
        result_next.process_id       = '0;
        result_next.served_level     = mlfq_pkg::LEVEL_ZERO;
        result_next.time_before_run  = '0;
        result_next.outcome          = mlfq_pkg::OUTCOME_FINISHED;
        result_next.now_time         = clock_reg;
        result_next.completion_total = comp_reg;
        result_next.waiting_total    = wsum_reg;
        result_next.process_total    = mlfq_pkg::TOTAL_W'(admit_reg);

        unique case (state_reg)
            mlfq_pkg::S_IDLE: begin
                item_ready = out_free || (!is_admit && !queue_empty);
                if (item_valid && item_ready) begin
                    if (is_admit) begin
                        load_out = 1'b1;
                        if (full) begin
                            result_next.status = mlfq_pkg::STATUS_REJECTED;
                        end else begin
                            mem_we = 1'b1;
                            result_next.status        = mlfq_pkg::STATUS_ADMITTED;
                            result_next.process_id    = mlfq_pkg::PID_W'(admit_reg);
                            result_next.process_total = mlfq_pkg::TOTAL_W'(admit_reg + 1'b1);
                        end
                    end else if (queue_empty) begin
                        load_out = 1'b1;
                    end
                end
            end
            mlfq_pkg::S_EXEC: begin
                // a preempted process goes back to the tail of its new level
                mem_we  = gt;
                wr_addr = slot_addr(target_lvl, tail_reg[target_lvl]);
                wr_data = {e_id, new_rem, e_burst};
            end
            mlfq_pkg::S_SUM: begin
            end
            mlfq_pkg::S_POST: begin
                load_out = out_free;
                result_next.status          = mlfq_pkg::STATUS_DISPATCHED;
                result_next.process_id      = mlfq_pkg::PID_W'(pid_reg);
                result_next.served_level    = lvl_reg;
                result_next.time_before_run = before_reg;
                result_next.outcome         = outcome_reg;
                result_next.waiting_total   = wsum_sat;
            end
        endcase
    end

    assign pop = item_valid && item_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mlfq_pkg::S_IDLE;
            fq_reg        <= mlfq_pkg::FIRST_QUANTUM_RST;
            sq_reg        <= mlfq_pkg::SECOND_QUANTUM_RST;
            pp_reg        <= mlfq_pkg::PROMOTE_PERIOD_RST;
            for (int i = 0; i < 3; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            clock_reg     <= '0;
            comp_reg      <= '0;
            wsum_reg      <= '0;
            prom_reg      <= '0;
            admit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                unique case (cfg_index)
                    mlfq_pkg::CFG_FIRST_QUANTUM:  fq_reg <= cfg_data;
                    mlfq_pkg::CFG_SECOND_QUANTUM: sq_reg <= cfg_data;
                    mlfq_pkg::CFG_PROMOTE_PERIOD: pp_reg <= cfg_data[mlfq_pkg::PERIOD_W-1:0];
                    default: ;
                endcase
            end

            out_valid_reg <= load_out || (out_valid_reg && !m_ready);

            unique case (state_reg)
                mlfq_pkg::S_IDLE: begin
                    if (pop) begin
                        if (is_admit) begin
                            if (!full) begin
                                tail_reg[item.level]  <= idx_inc(tail_reg[item.level]);
                                count_reg[item.level] <= count_reg[item.level] + 1'b1;
                                admit_reg             <= admit_reg + 1'b1;
                            end
                        end else if (!queue_empty) begin
                            head_reg[sel_lvl]  <= idx_inc(head_reg[sel_lvl]);
                            count_reg[sel_lvl] <= count_reg[sel_lvl] - 1'b1;
                        end
                    end
                end
                mlfq_pkg::S_EXEC: begin
                    clock_reg <= clock_adv;
                    if (gt) begin
                        tail_reg[target_lvl]  <= idx_inc(tail_reg[target_lvl]);
                        count_reg[target_lvl] <= count_reg[target_lvl] + 1'b1;
                        if (lvl_reg == mlfq_pkg::LEVEL_ONE) begin
                            prom_reg <= prom_next;
                        end
                    end
                end
                mlfq_pkg::S_SUM: begin
                    if (fin_reg) begin
                        comp_reg <= comp_sat;
                    end
                end
                mlfq_pkg::S_POST: begin
                    if (out_free) begin
                        wsum_reg <= wsum_sat;
                    end
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= result_next;
        end
        if (state_reg == mlfq_pkg::S_IDLE) begin
            lvl_reg <= sel_lvl;
        end
        if (state_reg == mlfq_pkg::S_EXEC) begin
            pid_reg     <= e_id;
            before_reg  <= mlfq_pkg::BEFORE_W'(e_rem);
            burst_reg   <= e_burst;
            fin_reg     <= !gt;
            outcome_reg <= exec_outcome;
        end
        if (state_reg == mlfq_pkg::S_SUM) begin
            winc_reg <= fin_reg ? wait_inc : '0;
        end
    end

    // queue store, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (state_reg == mlfq_pkg::S_IDLE) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    `ASSERT_ALWAYS(a_queued_within_admitted, aclk, aresetn,
                   queued_total <= QSUM_W'(admit_reg))
    `ASSERT_IMPLY(a_exec_follows_fetch, aclk, aresetn, state_reg == mlfq_pkg::S_EXEC,
                  $past(state_reg) == mlfq_pkg::S_IDLE)
    `ASSERT_NEXT(a_step_takes_one, aclk, aresetn,
                 state_reg == mlfq_pkg::S_IDLE && pop && !is_admit && !queue_empty,
                 queued_total == $past(queued_total) - 1'b1)

endmodule

`default_nettype wire

@@ hw/rtl/multilevel_feedback_queue_scheduler.sv @@
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Three-level feedback queue scheduler: admits processes into one of three
// levels and serves them on each step item, with time slices on levels zero and one.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake             payload
//  s_        in    s_tvalid / s_tready   tuser action, tdata level and burst
//  m_        out   m_tvalid / m_tready   tuser status, tdata result fields
//  cfg_      in    cfg_valid / cfg_ready cfg_index, cfg_data
//
//  an admit item is answered from the idle state through the registered result
//  a step runs idle (queue head read from the store), exec (run and clock update
//  with requeue write), sum (completion sum) and post (waiting sum and result)
//  an empty-queue step or a rejected admit is answered from the idle state
//  reset is synchronous; queue stores need no clearing, only pointers and counts
//  the front queue holds two items, so input is taken during a step until it is full
//
`default_nettype none

module multilevel_feedback_queue_scheduler #(
    parameter int unsigned MAX_PROCESSES = 16,
    parameter int unsigned TIME_WIDTH    = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [mlfq_pkg::S_TDATA_W-1:0]      s_tdata,   // queue_level, burst_time
    input  wire logic                                s_tuser,   // action
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [mlfq_pkg::M_TDATA_W-1:0]           m_tdata,   // process_id, served_level,
                                                                // time_before_run, outcome,
                                                                // now_time, completion_total,
                                                                // waiting_total, process_total
    output logic [mlfq_pkg::STATUS_W-1:0]            m_tuser,   // status
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mlfq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mlfq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned PAD_W = mlfq_pkg::M_TDATA_W - mlfq_pkg::M_FIELDS_W;

    logic               item_valid, item_ready;
    mlfq_pkg::item_t    item;
    mlfq_pkg::result_t  result;

    mlfq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    mlfq_back #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .m_valid    (m_tvalid),
        .m_result   (result),
        .m_ready    (m_tready)
    );

    // registers are always writable
    assign cfg_ready = 1'b1;

    assign m_tuser = result.status;
    assign m_tdata = {{PAD_W{1'b0}},
                      result.process_total,
                      result.waiting_total,
                      result.completion_total,
                      result.now_time,
                      result.outcome,
                      result.time_before_run,
                      result.served_level,
                      result.process_id};

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the three-level feedback queue scheduler with admit and step items,
// predicts every result with a behavioral model of the queues, the clock and
// the saturating sums, and compares each result field by field. Directed
// tests cover the levels, extreme bursts, zero quanta, a zero and a lowered
// promotion period and the capacity limit; random traffic under random
// configurations and random stalls on both sides runs before the capacity test.
// ----------------------------------------------------------------------------

module testbench;

    import mlfq_pkg::*;

    localparam int unsigned MAX_JOBS     = 16;
    localparam int unsigned RANDOM_ITEMS = 1550;
    localparam int unsigned RUN_LIMIT    = 300000;
    localparam int unsigned IDLE_PCT     = 35;

    // input word, lowest field last
    typedef struct packed {
        logic [S_TDATA_W-S_FIELDS_W-1:0] pad;
        logic [BURST_W-1:0]              burst_time;
        logic [LEVEL_W-1:0]              queue_level;
    } s_word_t;

    // result word, lowest field last
    typedef struct packed {
        logic [M_TDATA_W-M_FIELDS_W-1:0] pad;
        logic [TOTAL_W-1:0]              process_total;
        logic [SUM_W-1:0]                waiting_total;
        logic [SUM_W-1:0]                completion_total;
        logic [CLOCK_W-1:0]              now_time;
        logic [OUTCOME_W-1:0]            outcome;
        logic [BEFORE_W-1:0]             time_before_run;
        logic [LEVEL_W-1:0]              served_level;
        logic [PID_W-1:0]                process_id;
    } m_word_t;

    typedef struct packed {
        logic [PID_W-1:0]   id;
        logic [BURST_W-1:0] remain;
        logic [BURST_W-1:0] burst;
    } job_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;    // queue_level, burst_time
    logic                   s_tuser   = 1'b0;  // action
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;           // process_id, served_level, time_before_run,
                                               // outcome, now_time, completion_total,
                                               // waiting_total, process_total
    logic [STATUS_W-1:0]    m_tuser;           // status
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // scheduler model state
    job_t                  job_ring [3][MAX_JOBS];
    int unsigned           ring_head [3]  = '{0, 0, 0};
    int unsigned           ring_count [3] = '{0, 0, 0};
    logic [CLOCK_W-1:0]    now_clock      = '0;
    logic [SUM_W-1:0]      completion_acc = '0;
    logic [SUM_W-1:0]      waiting_acc    = '0;
    logic [PERIOD_W-1:0]   promote_count  = '0;
    int unsigned           admitted       = 0;
    logic [QUANTUM_W-1:0]  quantum_zero   = FIRST_QUANTUM_RST;
    logic [QUANTUM_W-1:0]  quantum_one    = SECOND_QUANTUM_RST;
    logic [PERIOD_W-1:0]   period_reg     = PROMOTE_PERIOD_RST;

    result_t     pending_results [$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    int unsigned idle_pct    = IDLE_PCT;

    multilevel_feedback_queue_scheduler #(
        .MAX_PROCESSES (MAX_JOBS),
        .TIME_WIDTH    (BURST_W)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // scheduler model
    // ------------------------------------------------------------------------

    function automatic void push_job(input int unsigned lvl, input job_t job);
        job_ring[lvl][(ring_head[lvl] + ring_count[lvl]) % MAX_JOBS] = job;
        ring_count[lvl]++;
    endfunction

    function automatic void run_for(input int unsigned amount);
        longint unsigned t;
        t = longint'(now_clock) + amount;
        now_clock = (t > CLOCK_MAX) ? CLOCK_MAX : CLOCK_W'(t);
    endfunction

    task automatic schedule_item(input kind_t kind, input logic [LEVEL_W-1:0] lvl_in,
                                 input logic [BURST_W-1:0] burst);
        result_t              r;
        job_t                 job;
        int unsigned          lvl;
        int unsigned          period;
        logic [QUANTUM_W-1:0] slice;
        longint unsigned      c;
        longint unsigned      w;
        r = '0;
        if (kind == KIND_ADMIT) begin
            if (admitted >= MAX_JOBS) begin
                r.status = STATUS_REJECTED;
            end else begin
                job = '{id: PID_W'(admitted), remain: burst, burst: burst};
                // level three joins level two
                push_job((lvl_in > LEVEL_TWO) ? 2 : lvl_in, job);
                r.status = STATUS_ADMITTED;
                r.process_id = job.id;
                admitted++;
            end
        end else begin
            lvl = 3;
            for (int i = 2; i >= 0; i--)
                if (ring_count[i] != 0) lvl = i;
            if (lvl == 3) begin
                r.status = STATUS_EMPTY;
            end else begin
                job = job_ring[lvl][ring_head[lvl]];
                ring_head[lvl] = (ring_head[lvl] + 1) % MAX_JOBS;
                ring_count[lvl]--;
                r.status = STATUS_DISPATCHED;
                r.process_id = job.id;
                r.served_level = level_t'(lvl);
                r.time_before_run = job.remain;
                slice = (lvl == 0) ? quantum_zero : quantum_one;
                if (lvl == 2 || job.remain <= slice) begin
                    run_for(job.remain);
                    c = longint'(completion_acc) + now_clock;
                    w = (now_clock > job.burst) ? longint'(now_clock) - job.burst : 0;
                    w += waiting_acc;
                    completion_acc = (c > SUM_MAX) ? SUM_MAX : SUM_W'(c);
                    waiting_acc = (w > SUM_MAX) ? SUM_MAX : SUM_W'(w);
                    r.outcome = OUTCOME_FINISHED;
                end else begin
                    job.remain -= slice;
                    run_for(slice);
                    if (lvl == 0) begin
                        push_job(1, job);
                        r.outcome = OUTCOME_TO_ONE;
                    end else begin
                        period = (period_reg == 0) ? 1 : period_reg;
                        if (promote_count == 0) begin
                            push_job(0, job);
                            r.outcome = OUTCOME_PROMOTED;
                        end else begin
                            push_job(2, job);
                            r.outcome = OUTCOME_TO_TWO;
                        end
                        // a count at or past a lowered period wraps on this move
                        promote_count = (promote_count + 1 >= period) ? '0 : promote_count + 1;
                    end
                end
            end
        end
        r.now_time = now_clock;
        r.completion_total = completion_acc;
        r.waiting_total = waiting_acc;
        r.process_total = TOTAL_W'(admitted);
        pending_results.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= idle_pct);

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        m_word_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                $error("result item arrived with none outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("process_id", want.process_id, got.process_id);
                check_field("served_level", want.served_level, got.served_level);
                check_field("time_before_run", want.time_before_run, got.time_before_run);
                check_field("outcome", want.outcome, got.outcome);
                check_field("now_time", want.now_time, got.now_time);
                check_field("completion_total", want.completion_total, got.completion_total);
                check_field("waiting_total", want.waiting_total, got.waiting_total);
                check_field("process_total", want.process_total, got.process_total);
                check_field("tdata padding", 0, got.pad);
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    task automatic send_item(input kind_t kind, input logic [LEVEL_W-1:0] lvl,
                             input logic [BURST_W-1:0] burst);
        s_word_t word;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        word = '{pad: '0, burst_time: burst, queue_level: lvl};
        s_tdata = word;
        s_tuser = kind;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        schedule_item(kind, lvl, burst);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_all_results();
        s_tvalid = 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_index = idx;
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_FIRST_QUANTUM:  quantum_zero = value;
            CFG_SECOND_QUANTUM: quantum_one = value;
            CFG_PROMOTE_PERIOD: period_reg = value[PERIOD_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // registers change only with the scheduler idle
    task automatic set_config(input logic [QUANTUM_W-1:0] q0, input logic [QUANTUM_W-1:0] q1,
                              input logic [PERIOD_W-1:0] period);
        wait_all_results();
        write_reg(CFG_FIRST_QUANTUM, q0);
        write_reg(CFG_SECOND_QUANTUM, q1);
        write_reg(CFG_PROMOTE_PERIOD, CFG_DATA_W'(period));
    endtask

    task automatic drain_queues();
        while (ring_count[0] + ring_count[1] + ring_count[2] != 0)
            send_item(KIND_STEP, LEVEL_ZERO, '0);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_levels_at_reset_config();
        send_item(KIND_STEP, LEVEL_ZERO, '0);
        send_item(KIND_ADMIT, LEVEL_ZERO, 16'd0);
        send_item(KIND_ADMIT, LEVEL_ONE, 16'd20);
        send_item(KIND_ADMIT, 2'd3, 16'd5);
        send_item(KIND_ADMIT, LEVEL_TWO, 16'hFFFF);
        send_item(KIND_ADMIT, LEVEL_ZERO, 16'd9);
        drain_queues();
        send_item(KIND_STEP, LEVEL_ZERO, '0);
    endtask

    task automatic test_zero_quantum_and_period();
        set_config(16'd0, 16'hFFFF, 4'd0);
        send_item(KIND_ADMIT, LEVEL_ZERO, 16'd3);
        send_item(KIND_ADMIT, LEVEL_ONE, 16'hFFFF);
        drain_queues();
    endtask

    task automatic test_lowered_period();
        set_config(16'd1, 16'd1, 4'd15);
        send_item(KIND_ADMIT, LEVEL_ZERO, 16'd6);
        drain_queues();
        set_config(16'd1, 16'd1, 4'd2);
        send_item(KIND_ADMIT, LEVEL_ONE, 16'd5);
        drain_queues();
    endtask

    function automatic logic [QUANTUM_W-1:0] pick_quantum();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return QUANTUM_W'($urandom);
            default: return QUANTUM_W'($urandom_range(1, 24));
        endcase
    endfunction

    task automatic test_random_traffic();
        int unsigned          start;
        int unsigned          done;
        int unsigned          count;
        logic [QUANTUM_W-1:0] q0;
        logic [QUANTUM_W-1:0] q1;
        logic [BURST_W-1:0]   burst;
        start = items_sent;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            q0 = pick_quantum();
            q1 = pick_quantum();
            set_config(q0, q1, PERIOD_W'($urandom_range(15)));
            count = $urandom_range(30, 120);
            if (count > RANDOM_ITEMS - done)
                count = RANDOM_ITEMS - done;
            repeat (count) begin
                // a long stretch with both sides streaming at full rate
                idle_pct = (done >= 500 && done < 800) ? 0 : IDLE_PCT;
                burst = ($urandom_range(1)) ? BURST_W'($urandom) : BURST_W'($urandom_range(40));
                if ($urandom_range(99) < 25)
                    send_item(KIND_ADMIT, LEVEL_W'($urandom_range(3)), burst);
                else
                    send_item(KIND_STEP, LEVEL_W'($urandom_range(3)), burst);
                done = items_sent - start;
            end
        end
        idle_pct = IDLE_PCT;
    endtask

    task automatic test_capacity_reached();
        wait_all_results();
        send_item(KIND_ADMIT, LEVEL_ZERO, 16'hFFFF);
        send_item(KIND_ADMIT, LEVEL_ONE, 16'd1);
        send_item(KIND_ADMIT, 2'd3, 16'd0);
        send_item(KIND_STEP, LEVEL_ZERO, '0);
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_levels_at_reset_config();
        test_zero_quantum_and_period();
        test_lowered_period();
        test_random_traffic();
        test_capacity_reached();
        wait_all_results();
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ multilevel_feedback_queue_scheduler.f @@
+incdir+hw/rtl
hw/rtl/mlfq_pkg.sv
hw/rtl/mlfq_front.sv
hw/rtl/mlfq_back.sv
hw/rtl/multilevel_feedback_queue_scheduler.sv
bench/testbench.sv
